// ===== design/fpa_pkg.sv =====
// Package for the fixed-point ALU: widths, command codes and the beat
// and pipeline payload types. No dependencies.
package fpa_pkg;

    localparam int FRAC_BITS = 8;
    localparam int DATA_W    = 32;
    localparam int NUM_W     = DATA_W + FRAC_BITS;
    // One quotient bit per divider stage
    localparam int DIV_STEPS = NUM_W;

    typedef enum logic [2:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_MIN = 3'd4,
        CMD_MAX = 3'd5
    } cmd_t;

    typedef struct packed {
        logic [2:0]               command;
        logic signed [DATA_W-1:0] operand_a;
        logic signed [DATA_W-1:0] operand_b;
    } fpa_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_raw;
        logic                     a_greater;
        logic                     a_less;
        logic                     a_equal;
        logic                     divide_by_zero;
    } fpa_rsp_t;

    // Divider stage state
    typedef struct packed {
        logic [DATA_W-1:0] rem;
        logic [NUM_W-1:0]  num;
        logic [DATA_W-1:0] quo;
        logic [DATA_W-1:0] den;
        logic              neg;
    } fpa_div_t;

    // Side information riding alongside the divider
    typedef struct packed {
        logic [2:0]        command;
        logic [DATA_W-1:0] simple;
        logic [DATA_W-1:0] mul;
        logic              a_greater;
        logic              a_less;
        logic              a_equal;
        logic              dz;
    } fpa_side_t;

endpackage

// ===== design/fpa_mul.sv =====
// Multiplier of the fixed-point ALU: registered magnitude product, then
// sign fix and arithmetic shift. Uses fpa_pkg.
module fpa_mul
    import fpa_pkg::*;
(
    input  logic              clk,
    input  logic [DATA_W-1:0] mag_a,
    input  logic [DATA_W-1:0] mag_b,
    input  logic              neg,
    output logic [DATA_W-1:0] product
);

    logic [2*DATA_W-1:0]        prod_reg;
    logic                       neg_reg;
    logic signed [2*DATA_W-1:0] signed_prod;
    logic signed [2*DATA_W-1:0] shifted;

    // Unsigned magnitude product
    always_ff @(posedge clk)
    begin
        prod_reg <= mag_a * mag_b;
        neg_reg  <= neg;
    end

    // Apply sign, scale back by the fraction width
    always_comb
    begin
        signed_prod = neg_reg ? -$signed(prod_reg) : $signed(prod_reg);
        shifted     = signed_prod >>> FRAC_BITS;
        product     = shifted[DATA_W-1:0];
    end

endmodule

// ===== design/fpa_div_step.sv =====
// One restoring-division stage of the fixed-point ALU: one quotient bit
// per stage, registered. Uses fpa_pkg.
module fpa_div_step
    import fpa_pkg::*;
(
    input  logic     clk,
    input  fpa_div_t d_in,
    output fpa_div_t d_out
);

    fpa_div_t          step_next;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;
    logic              ge;

    // Shift in next dividend bit, trial subtract
    always_comb
    begin
        shifted   = {d_in.rem, d_in.num[NUM_W-1]};
        diff      = shifted - {1'b0, d_in.den};
        ge        = shifted >= {1'b0, d_in.den};
        step_next = d_in;
        step_next.rem = ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
        step_next.num = {d_in.num[NUM_W-2:0], 1'b0};
        step_next.quo = {d_in.quo[DATA_W-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        d_out <= step_next;
    end

endmodule

// ===== design/fixed_point_alu_top.sv =====
// Top level of the fixed-point ALU (Q24.8): input register, multiplier,
// pipelined divider, side delay line, output register. Uses fpa_pkg.
//
// Usage:
//   A command beat (request) is taken at each clock edge where start is
//   high and busy is low. busy is always low: the pipeline takes one beat
//   every cycle, back to back.
//   Each beat gives exactly one response beat, shown for one cycle with
//   done high. Results leave in the order the commands came in.
//   Every command takes the same path: one input register, one divider
//   stage per quotient bit, one output register. The divider chain sets
//   the depth of the path; add, subtract, min, max and multiply ride a
//   delay line to keep order.
//   Throughput is one beat per cycle.
//   Reset clears the valid bits and done; beats in flight are dropped.
//   The receiver cannot stall: a response is taken in the cycle it shows.
//   Divide by zero gives a zero result with divide_by_zero set.
module fixed_point_alu_top
    import fpa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  fpa_req_t request,
    output logic     done,
    output fpa_rsp_t response
);

    logic              in_valid_reg;
    fpa_req_t          in_reg;
    logic [DATA_W-1:0] a_u;
    logic [DATA_W-1:0] b_u;
    logic [DATA_W-1:0] mag_a;
    logic [DATA_W-1:0] mag_b;
    logic              neg;
    fpa_side_t         side_next;
    fpa_side_t         side_mul;
    fpa_div_t          div_first;
    logic [DATA_W-1:0] mul_out;

    logic              valid_reg [DIV_STEPS];
    fpa_side_t         side_reg  [DIV_STEPS];
    fpa_div_t          div_chain [DIV_STEPS+1];

    fpa_side_t         last;
    fpa_div_t          dlast;
    fpa_rsp_t          rsp_next;
    logic [DATA_W-1:0] quo_signed;

    logic              done_reg;
    fpa_rsp_t          rsp_reg;

    assign busy = 1'b0;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= start & ~busy;
    end

    always_ff @(posedge clk)
    begin
        in_reg <= request;
    end

    // Compare, simple ops, magnitudes
    always_comb
    begin
        a_u   = in_reg.operand_a;
        b_u   = in_reg.operand_b;
        mag_a = a_u[DATA_W-1] ? (~a_u + 1'b1) : a_u;
        mag_b = b_u[DATA_W-1] ? (~b_u + 1'b1) : b_u;
        neg   = a_u[DATA_W-1] ^ b_u[DATA_W-1];

        side_next           = '0;
        side_next.command   = in_reg.command;
        side_next.a_greater = in_reg.operand_a > in_reg.operand_b;
        side_next.a_less    = in_reg.operand_a < in_reg.operand_b;
        side_next.a_equal   = in_reg.operand_a == in_reg.operand_b;
        side_next.dz        = (in_reg.command == CMD_DIV) && (b_u == '0);
        case (in_reg.command)
            CMD_ADD: side_next.simple = a_u + b_u;
            CMD_SUB: side_next.simple = a_u - b_u;
            CMD_MIN: side_next.simple = side_next.a_less ? a_u : b_u;
            CMD_MAX: side_next.simple = side_next.a_greater ? a_u : b_u;
            default: side_next.simple = '0;
        endcase

        div_first.rem = '0;
        div_first.num = {mag_a, {FRAC_BITS{1'b0}}};
        div_first.quo = '0;
        div_first.den = mag_b;
        div_first.neg = neg;
    end

    assign div_chain[0] = div_first;

    fpa_mul u_mul (
        .clk     (clk),
        .mag_a   (mag_a),
        .mag_b   (mag_b),
        .neg     (neg),
        .product (mul_out)
    );

    // Divider chain
    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        fpa_div_step u_step (
            .clk   (clk),
            .d_in  (div_chain[i]),
            .d_out (div_chain[i+1])
        );
    end

    // Side delay line; multiplier result joins at the second slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_STEPS; i++)
                valid_reg[i] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid_reg;
            for (int i = 1; i < DIV_STEPS; i++)
                valid_reg[i] <= valid_reg[i-1];
        end
    end

    always_comb
    begin
        side_mul     = side_reg[0];
        side_mul.mul = mul_out;
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_next;
        side_reg[1] <= side_mul;
        for (int i = 2; i < DIV_STEPS; i++)
            side_reg[i] <= side_reg[i-1];
    end

    // Result select
    always_comb
    begin
        last       = side_reg[DIV_STEPS-1];
        dlast      = div_chain[DIV_STEPS];
        quo_signed = dlast.neg ? (~dlast.quo + 1'b1) : dlast.quo;

        rsp_next                = '0;
        rsp_next.a_greater      = last.a_greater;
        rsp_next.a_less         = last.a_less;
        rsp_next.a_equal        = last.a_equal;
        rsp_next.divide_by_zero = last.dz;
        case (last.command)
            CMD_ADD, CMD_SUB, CMD_MIN, CMD_MAX:
                rsp_next.result_raw = last.simple;
            CMD_MUL:
                rsp_next.result_raw = last.mul;
            CMD_DIV:
                rsp_next.result_raw = last.dz ? '0 : quo_signed;
            default:
                rsp_next.result_raw = '0;
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= valid_reg[DIV_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done     = done_reg;
    assign response = rsp_reg;

endmodule
